// ===== src/distinct_window_marker_detect_unit_defines.svh =====
// Assertion helpers used by the detector core.
// Each expects clk and rst_n in scope.
`ifndef DISTINCT_WINDOW_MARKER_DETECT_UNIT_DEFINES_SVH
`define DISTINCT_WINDOW_MARKER_DETECT_UNIT_DEFINES_SVH

// same-cycle implication
`define DWMD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwmd check failed");

// next-cycle implication
`define DWMD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwmd check failed");

`endif

// ===== src/dwmd_pkg.sv =====
`default_nettype none
package dwmd_pkg;

    localparam int SYM_W      = 8;
    localparam int POS_W      = 20;
    localparam int WL_W       = 4;
    localparam int WL_MIN     = 2;
    localparam int OUT_DATA_W = 24;
    localparam int ADDR_W     = 3;
    localparam int APB_W      = 32;

    localparam logic [WL_W-1:0] WL_RESET = 4'd4;

    // word index of each register (paddr[2])
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             restart;
    } dwmd_item_t;

endpackage
`default_nettype wire

// ===== src/distinct_window_marker_detect_unit.sv =====
`default_nettype none
// Distinct-window marker detector.
// Slave stream: one symbol per transfer. s_tdata[7:0] = symbol, s_tuser = restart
// (clears run length, count and marker latch before this symbol is taken).
// Master stream: one result per input transfer, in order. m_tdata bit 0 = found
// (first symbol completing a window of window_length all-different symbols),
// bit 1 = marker_seen, bits 21:2 = position (1-based symbol count, saturating).
// APB register at address 0: window_length[3:0], reset 4, clamped to
// 2..MAX_WINDOW when used. Write only while the stream is idle.
// Path: the input register takes each transfer and the result register loads
// from it when the core is ready, so m_tvalid is high once that load is done.
// Throughput: one symbol per cycle while m_tready is high; the match search over
// the stored history and the result register sit in one stage.
// Stall: when m_tready is low the result register holds, the input register
// fills, and s_tready drops as soon as both hold a symbol; nothing is lost.
// Reset: asynchronous, active low; clears stream state and both valid flags,
// and sets window_length to 4.
module distinct_window_marker_detect_unit #(
    parameter int MAX_WINDOW = 14,
    parameter int COUNT_BITS = 20
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dwmd_pkg::SYM_W-1:0]      s_tdata,  // [7:0] symbol
    input  wire logic                            s_tuser,  // [0] restart
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] found, [1] marker_seen, [21:2] position, [23:22] zero
    output logic [dwmd_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dwmd_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [dwmd_pkg::APB_W-1:0]      pwdata,
    output logic [dwmd_pkg::APB_W-1:0]           prdata,
    output logic                                 pready
);
    import dwmd_pkg::*;

    dwmd_item_t      item;
    logic            core_ready;
    logic [WL_W-1:0] window_length;

    dwmd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (item),
        .down_ready (core_ready)
    );

    dwmd_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .window_length (window_length)
    );

    dwmd_core #(
        .MAX_WINDOW (MAX_WINDOW),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .ready         (core_ready),
        .window_length (window_length),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
`default_nettype wire

// ===== src/dwmd_in_reg.sv =====
`default_nettype none
module dwmd_in_reg
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [dwmd_pkg::SYM_W-1:0] s_tdata,
    input  wire logic                      s_tuser,
    output dwmd_pkg::dwmd_item_t           item,
    input  wire logic                      down_ready
);
    import dwmd_pkg::*;

    logic             valid_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic             restart_reg;

    assign s_tready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            symbol_reg  <= s_tdata;
            restart_reg <= s_tuser;
        end
    end

    assign item.valid   = valid_reg;
    assign item.symbol  = symbol_reg;
    assign item.restart = restart_reg;

endmodule
`default_nettype wire

// ===== src/dwmd_cfg.sv =====
`default_nettype none
module dwmd_cfg
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dwmd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dwmd_pkg::APB_W-1:0]  pwdata,
    output logic [dwmd_pkg::APB_W-1:0]       prdata,
    output logic                            pready,
    output logic [dwmd_pkg::WL_W-1:0]        window_length
);
    import dwmd_pkg::*;

    logic [WL_W-1:0] window_length_reg;
    logic            wr_en;

    assign pready = 1'b1;
    // word decode: low address bits ignored
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WL_RESET;
        end
        else if (wr_en)
        begin
            window_length_reg <= pwdata[WL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_LENGTH)
        begin
            prdata = {{(APB_W-WL_W){1'b0}}, window_length_reg};
        end
    end

    assign window_length = window_length_reg;

endmodule
`default_nettype wire

// ===== src/dwmd_core.sv =====
`default_nettype none
`include "distinct_window_marker_detect_unit_defines.svh"
module dwmd_core #(
    parameter int MAX_WINDOW = 14,
    parameter int COUNT_BITS = 20
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dwmd_pkg::dwmd_item_t          item,
    output logic                               ready,
    input  wire logic [dwmd_pkg::WL_W-1:0]     window_length,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dwmd_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import dwmd_pkg::*;

    localparam int RUN_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (RUN_W > WL_W) ? RUN_W : WL_W;
    localparam logic [LEN_W-1:0]      LEN_MIN = LEN_W'(WL_MIN);
    localparam logic [LEN_W-1:0]      LEN_MAX = LEN_W'(MAX_WINDOW);
    localparam logic [RUN_W-1:0]      RUN_MAX = RUN_W'(MAX_WINDOW);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // newest symbol at index 0
    logic [SYM_W-1:0]      hist_reg [MAX_WINDOW];
    // length of the longest all-distinct run ending at the newest symbol, capped
    logic [RUN_W-1:0]      run_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  latched_reg;

    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic                  out_seen_reg;
    logic [POS_W-1:0]      out_pos_reg;

    logic                  adv;
    logic [RUN_W-1:0]      run_cur;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic                  latched_cur;
    logic                  hit_any;
    logic [RUN_W-1:0]      hit_dist;
    logic [RUN_W-1:0]      run_inc;
    logic [RUN_W-1:0]      run_next;
    logic [LEN_W-1:0]      wl_ext;
    logic [LEN_W-1:0]      len_eff;
    logic                  found_next;
    logic                  latched_next;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [POS_W-1:0]      pos_next;

    assign ready = !out_valid_reg || m_tready;
    assign adv   = item.valid && ready;

    always_comb
    begin
        run_cur     = item.restart ? '0 : run_reg;
        cnt_cur     = item.restart ? '0 : cnt_reg;
        latched_cur = item.restart ? 1'b0 : latched_reg;

        // nearest earlier copy of the new symbol; stale entries beyond the
        // run never shorten it, so no fill tracking is needed
        hit_any  = 1'b0;
        hit_dist = '0;
        for (int k = MAX_WINDOW - 1; k >= 0; k--)
        begin
            if (hist_reg[k] == item.symbol)
            begin
                hit_any  = 1'b1;
                hit_dist = RUN_W'(k + 1);
            end
        end

        run_inc  = (run_cur == RUN_MAX) ? RUN_MAX : run_cur + RUN_W'(1);
        run_next = (hit_any && (hit_dist < run_inc)) ? hit_dist : run_inc;

        wl_ext = LEN_W'(window_length);
        priority if (wl_ext < LEN_MIN)
        begin
            len_eff = LEN_MIN;
        end
        else if (wl_ext > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = wl_ext;
        end

        found_next   = !latched_cur && (LEN_W'(run_next) >= len_eff);
        latched_next = latched_cur || found_next;
        cnt_next     = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    end

    generate
        if (COUNT_BITS >= POS_W)
        begin : g_pos_trunc
            assign pos_next = cnt_next[POS_W-1:0];
        end
        else
        begin : g_pos_ext
            assign pos_next = {{(POS_W-COUNT_BITS){1'b0}}, cnt_next};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                hist_reg[k] <= '0;
            end
            run_reg       <= '0;
            cnt_reg       <= '0;
            latched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                hist_reg[0] <= item.symbol;
                for (int k = 1; k < MAX_WINDOW; k++)
                begin
                    hist_reg[k] <= hist_reg[k-1];
                end
                run_reg     <= run_next;
                cnt_reg     <= cnt_next;
                latched_reg <= latched_next;
            end
            if (ready)
            begin
                out_valid_reg <= item.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_found_reg <= found_next;
            out_seen_reg  <= latched_next;
            out_pos_reg   <= pos_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-POS_W-2){1'b0}}, out_pos_reg, out_seen_reg, out_found_reg};

    `DWMD_ASSERT_IMP(a_found_sets_seen, out_valid_reg && out_found_reg, out_seen_reg)
    `DWMD_ASSERT_IMP(a_found_matches_latch, out_valid_reg && out_found_reg, latched_reg)
    `DWMD_ASSERT_IMP(a_run_capped, 1'b1, run_reg <= RUN_MAX)
    `DWMD_ASSERT_NXT(a_latch_holds, adv && !item.restart && latched_reg, latched_reg)

endmodule
`default_nettype wire
